### design/pocn_pkg.sv
// Shared types and constants for the parking occupancy node controller.
// Used by pocn_cfg, pocn_sense, pocn_link and the top level.
package pocn_pkg;

    localparam int unsigned SAMPLE_PERIOD_MS = 200;
    localparam int unsigned RANGE_MAX_MM     = 8000;

    localparam logic signed [15:0] MAG_BASELINE_RST   = 16'sd0;
    localparam logic [15:0]        MAG_THRESHOLD_RST  = 16'd128;
    localparam logic [12:0]        NEAR_LIMIT_RST     = 13'd750;
    localparam logic [15:0]        CONFIRM_MS_RST     = 16'd3000;
    localparam logic [15:0]        ACK_TIMEOUT_RST    = 16'd1200;
    localparam logic [3:0]         MAX_RETRIES_RST    = 4'd10;
    localparam logic [31:0]        HEARTBEAT_MS_RST   = 32'd30000;
    localparam logic [15:0]        BLINK_MS_RST       = 16'd400;

    typedef enum logic [2:0] {
        CFG_MAG_BASELINE  = 3'd0,
        CFG_MAG_THRESHOLD = 3'd1,
        CFG_NEAR_LIMIT    = 3'd2,
        CFG_CONFIRM_MS    = 3'd3,
        CFG_ACK_TIMEOUT   = 3'd4,
        CFG_MAX_RETRIES   = 3'd5,
        CFG_HEARTBEAT_MS  = 3'd6,
        CFG_BLINK_MS      = 3'd7
    } t_cfg_index;

    typedef enum logic [1:0] {
        ACT_LOOP     = 2'd0,
        ACT_DECISION = 2'd1,
        ACT_ACK      = 2'd2,
        ACT_UNUSED   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        OVR_NONE      = 2'd0,
        OVR_RESERVED  = 2'd1,
        OVR_VIOLATION = 2'd2,
        OVR_MAINT     = 2'd3
    } t_override;

    typedef enum logic [1:0] {
        SEND_BOOT      = 2'd0,
        SEND_CHANGE    = 2'd1,
        SEND_RETRY     = 2'd2,
        SEND_HEARTBEAT = 2'd3
    } t_send_kind;

    typedef struct packed {
        logic signed [15:0] mag_baseline;
        logic [15:0]        mag_threshold;
        logic [12:0]        near_limit_mm;
        logic [15:0]        confirm_ms;
        logic [15:0]        ack_wait_ms;
        logic [3:0]         max_retries;
        logic [31:0]        heartbeat_ms;
        logic [15:0]        blink_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        now_ms;
        logic               range_ready;
        logic               range_error;
        logic [15:0]        range_mm;
        logic signed [15:0] mag_z;
        logic               for_this_node;
        logic [1:0]         decision_code;
    } t_item;

    // Occupancy view after the current transaction
    typedef struct packed {
        logic        sampled;
        logic        occupied;
        logic [12:0] distance_mm;   // 0 when out of range
    } t_sense;

    typedef struct packed {
        logic        lamp_red;
        logic        lamp_yellow;
        logic        lamp_green;
        logic        buzzer_on;
        logic        send_valid;
        logic [1:0]  send_kind;
        logic        sent_occupied;
        logic [12:0] sent_distance_mm;
        logic        gave_up;
        logic [1:0]  override_mode;
    } t_result;

endpackage

### design/pocn_cfg.sv
// Configuration register file of the parking occupancy node controller.
// Depends on pocn_pkg for the register indexes and the t_cfg bundle.
module pocn_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output logic              o_cfg_ready,
    output pocn_pkg::t_cfg    o_cfg
);
    import pocn_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mag_baseline   <= MAG_BASELINE_RST;
            r_cfg.mag_threshold  <= MAG_THRESHOLD_RST;
            r_cfg.near_limit_mm  <= NEAR_LIMIT_RST;
            r_cfg.confirm_ms     <= CONFIRM_MS_RST;
            r_cfg.ack_wait_ms    <= ACK_TIMEOUT_RST;
            r_cfg.max_retries    <= MAX_RETRIES_RST;
            r_cfg.heartbeat_ms   <= HEARTBEAT_MS_RST;
            r_cfg.blink_ms       <= BLINK_MS_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MAG_BASELINE:  r_cfg.mag_baseline   <= i_cfg_data[15:0];
                CFG_MAG_THRESHOLD: r_cfg.mag_threshold  <= i_cfg_data[15:0];
                CFG_NEAR_LIMIT:    r_cfg.near_limit_mm  <= i_cfg_data[12:0];
                CFG_CONFIRM_MS:    r_cfg.confirm_ms     <= i_cfg_data[15:0];
                CFG_ACK_TIMEOUT:   r_cfg.ack_wait_ms    <= i_cfg_data[15:0];
                CFG_MAX_RETRIES:   r_cfg.max_retries    <= i_cfg_data[3:0];
                CFG_HEARTBEAT_MS:  r_cfg.heartbeat_ms   <= i_cfg_data;
                CFG_BLINK_MS:      r_cfg.blink_ms       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

### design/pocn_sense.sv
// Sensor sampling and occupancy decision: distance capture, magnetic
// confirm timer and occupied flag. Depends on pocn_pkg.
module pocn_sense (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,     // a loop pass is processed this cycle
    input  pocn_pkg::t_cfg    i_cfg,
    input  pocn_pkg::t_item   i_item,
    output pocn_pkg::t_sense  o_sense
);
    import pocn_pkg::*;

    logic [31:0] r_last_sample, n_last_sample;
    logic [31:0] r_confirm_start, n_confirm_start;
    logic        r_confirm_run, n_confirm_run;
    logic        r_mag_conf, n_mag_conf;
    logic [12:0] r_dist, n_dist;
    logic        r_far, n_far;
    logic        r_occ, n_occ;

    logic [31:0] since_sample;
    logic [31:0] confirm_elapsed;
    logic signed [16:0] mag_delta;
    logic [16:0] mag_abs;
    logic        due;

    always_comb begin
        since_sample    = i_item.now_ms - r_last_sample;
        due             = i_step && (since_sample >= 32'(SAMPLE_PERIOD_MS));
        mag_delta       = {i_item.mag_z[15], i_item.mag_z}
                        - {i_cfg.mag_baseline[15], i_cfg.mag_baseline};
        mag_abs         = mag_delta[16] ? 17'(-mag_delta) : 17'(mag_delta);
        // timer starting on this sample has zero elapsed time
        confirm_elapsed = r_confirm_run ? (i_item.now_ms - r_confirm_start) : 32'd0;

        n_last_sample   = r_last_sample;
        n_confirm_start = r_confirm_start;
        n_confirm_run   = r_confirm_run;
        n_mag_conf      = r_mag_conf;
        n_dist          = r_dist;
        n_far           = r_far;
        n_occ           = r_occ;

        if (due) begin
            n_last_sample = i_item.now_ms;
            if (i_item.range_ready) begin
                if (i_item.range_error || (i_item.range_mm > 16'(RANGE_MAX_MM))) begin
                    n_far = 1'b1;
                end else begin
                    n_far  = 1'b0;
                    n_dist = i_item.range_mm[12:0];
                end
            end
            if (mag_abs > {1'b0, i_cfg.mag_threshold}) begin
                n_confirm_run = 1'b1;
                if (!r_confirm_run) begin
                    n_confirm_start = i_item.now_ms;
                end
                if (confirm_elapsed > {16'd0, i_cfg.confirm_ms}) begin
                    n_mag_conf = 1'b1;
                end
            end else begin
                n_confirm_run = 1'b0;
                n_mag_conf    = 1'b0;
            end
            n_occ = !n_far && (n_dist < i_cfg.near_limit_mm) && n_mag_conf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sample   <= '0;
            r_confirm_start <= '0;
            r_confirm_run   <= 1'b0;
            r_mag_conf      <= 1'b0;
            r_dist          <= '0;
            r_far           <= 1'b1;
            r_occ           <= 1'b0;
        end else begin
            r_last_sample   <= n_last_sample;
            r_confirm_start <= n_confirm_start;
            r_confirm_run   <= n_confirm_run;
            r_mag_conf      <= n_mag_conf;
            r_dist          <= n_dist;
            r_far           <= n_far;
            r_occ           <= n_occ;
        end
    end

    assign o_sense.sampled     = due;
    assign o_sense.occupied    = n_occ;
    assign o_sense.distance_mm = n_far ? 13'd0 : n_dist;

endmodule

### design/pocn_link.sv
// Status send scheduling (boot, change, retry, heartbeat), acknowledge
// handling, override mode and lamp drive. Depends on pocn_pkg.
module pocn_link (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,      // the held transaction is processed
    input  pocn_pkg::t_cfg    i_cfg,
    input  pocn_pkg::t_item   i_item,
    input  pocn_pkg::t_sense  i_sense,
    output pocn_pkg::t_result o_result
);
    import pocn_pkg::*;

    t_override   r_override, n_override;
    logic        r_reported, n_reported;
    logic        r_boot_sent, n_boot_sent;
    logic        r_awaiting, n_awaiting;
    logic [31:0] r_last_send, n_last_send;
    logic [3:0]  r_retry, n_retry;
    logic [31:0] r_last_blink, n_last_blink;
    logic        r_blink, n_blink;
    logic [31:0] r_last_hb, n_last_hb;

    logic        is_loop, is_dec, is_ack;
    logic        boot_snd, chg_snd, first_snd;
    logic        retry_due, retry_snd, give_up;
    logic        await_mid, hb_due, hb_snd, any_snd;
    t_send_kind  kind;

    always_comb begin
        is_loop = i_adv && (t_action'(i_item.action) == ACT_LOOP);
        is_dec  = i_adv && (t_action'(i_item.action) == ACT_DECISION)
                  && i_item.for_this_node;
        is_ack  = i_adv && (t_action'(i_item.action) == ACT_ACK)
                  && i_item.for_this_node && r_awaiting;

        boot_snd  = i_sense.sampled && !r_boot_sent;
        // after a boot send the reported state already matches
        chg_snd   = i_sense.sampled && r_boot_sent && !r_awaiting
                    && (i_sense.occupied != r_reported);
        first_snd = boot_snd || chg_snd;

        retry_due = is_loop && !first_snd && r_awaiting
                    && ((i_item.now_ms - r_last_send) >= {16'd0, i_cfg.ack_wait_ms});
        retry_snd = retry_due && (r_retry < i_cfg.max_retries);
        give_up   = retry_due && !retry_snd;
        await_mid = first_snd || (r_awaiting && !give_up);

        hb_due  = is_loop && ((i_item.now_ms - r_last_hb) >= i_cfg.heartbeat_ms);
        hb_snd  = hb_due && !await_mid;
        any_snd = first_snd || retry_snd || hb_snd;

        if (boot_snd) begin
            kind = SEND_BOOT;
        end else if (chg_snd) begin
            kind = SEND_CHANGE;
        end else if (retry_snd) begin
            kind = SEND_RETRY;
        end else begin
            kind = SEND_HEARTBEAT;
        end
    end

    always_comb begin
        n_override   = r_override;
        n_reported   = r_reported;
        n_boot_sent  = r_boot_sent;
        n_awaiting   = r_awaiting;
        n_last_send  = r_last_send;
        n_retry      = r_retry;
        n_last_blink = r_last_blink;
        n_blink      = r_blink;
        n_last_hb    = r_last_hb;

        if (is_dec) begin
            n_override = t_override'(i_item.decision_code);
        end
        if (is_ack) begin
            n_awaiting = 1'b0;
            n_retry    = '0;
        end
        if (i_sense.sampled) begin
            n_boot_sent = 1'b1;
        end
        if (first_snd) begin
            n_reported = i_sense.occupied;
        end
        if (is_loop && (r_override == OVR_VIOLATION)
            && ((i_item.now_ms - r_last_blink) >= {16'd0, i_cfg.blink_ms})) begin
            n_last_blink = i_item.now_ms;
            n_blink      = !r_blink;
        end
        if (give_up) begin
            n_awaiting = 1'b0;
            n_retry    = '0;
        end
        if (retry_snd) begin
            n_retry = r_retry + 4'd1;
        end
        if (first_snd || hb_snd) begin
            n_retry = '0;
        end
        if (hb_due) begin
            n_last_hb = i_item.now_ms;
        end
        if (any_snd) begin
            n_awaiting  = 1'b1;
            n_last_send = i_item.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_override   <= OVR_NONE;
            r_reported   <= 1'b0;
            r_boot_sent  <= 1'b0;
            r_awaiting   <= 1'b0;
            r_last_send  <= '0;
            r_retry      <= '0;
            r_last_blink <= '0;
            r_blink      <= 1'b0;
            r_last_hb    <= '0;
        end else begin
            r_override   <= n_override;
            r_reported   <= n_reported;
            r_boot_sent  <= n_boot_sent;
            r_awaiting   <= n_awaiting;
            r_last_send  <= n_last_send;
            r_retry      <= n_retry;
            r_last_blink <= n_last_blink;
            r_blink      <= n_blink;
            r_last_hb    <= n_last_hb;
        end
    end

    // lamps reflect the state after this transaction
    always_comb begin
        o_result             = '0;
        o_result.send_valid  = any_snd;
        o_result.gave_up     = give_up;
        o_result.override_mode = n_override;
        if (any_snd) begin
            o_result.send_kind        = kind;
            o_result.sent_occupied    = i_sense.occupied;
            o_result.sent_distance_mm = i_sense.distance_mm;
        end
        case (n_override)
            OVR_MAINT: ;
            OVR_VIOLATION: begin
                o_result.buzzer_on   = 1'b1;
                o_result.lamp_red    = n_blink;
                o_result.lamp_yellow = !n_blink;
            end
            OVR_RESERVED: o_result.lamp_yellow = 1'b1;
            default: begin
                o_result.lamp_red   = i_sense.occupied;
                o_result.lamp_green = !i_sense.occupied;
            end
        endcase
    end

endmodule

### design/parking_occupancy_node_controller_unit.sv
// Top level of the parking occupancy node controller: input register,
// result register and handshake. Depends on pocn_pkg, pocn_cfg,
// pocn_sense and pocn_link.
//
//  channel   direction  handshake              payload
//  item      in         i_valid / o_stall      i_action .. i_decision_code
//  result    out        o_valid / i_stall      o_lamp_red .. o_override_mode
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each transaction gives one result: it is held first in the input register,
// then in the result register. A new transaction can be accepted every cycle;
// o_stall rises only when both registers are full and the result is held by
// i_stall. Reset is synchronous (i_rst_n low) and puts the configuration and
// node state at their power-on values.
module parking_occupancy_node_controller_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_now_ms,
    input  logic               i_range_ready,
    input  logic               i_range_error,
    input  logic [15:0]        i_range_mm,
    input  logic signed [15:0] i_mag_z,
    input  logic               i_for_this_node,
    input  logic [1:0]         i_decision_code,

    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_lamp_red,
    output logic               o_lamp_yellow,
    output logic               o_lamp_green,
    output logic               o_buzzer_on,
    output logic               o_send_valid,
    output logic [1:0]         o_send_kind,
    output logic               o_sent_occupied,
    output logic [12:0]        o_sent_distance_mm,
    output logic               o_gave_up,
    output logic [1:0]         o_override_mode,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import pocn_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_sense  sense;
    t_result result;
    logic    adv;
    logic    accept;
    logic    loop_step;

    assign adv       = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !adv;
    assign accept    = i_valid && !o_stall;
    assign loop_step = adv && (t_action'(r_item.action) == ACT_LOOP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.action        <= i_action;
            r_item.now_ms        <= i_now_ms;
            r_item.range_ready   <= i_range_ready;
            r_item.range_error   <= i_range_error;
            r_item.range_mm      <= i_range_mm;
            r_item.mag_z         <= i_mag_z;
            r_item.for_this_node <= i_for_this_node;
            r_item.decision_code <= i_decision_code;
        end
    end

    pocn_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    pocn_sense u_sense (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (loop_step),
        .i_cfg   (cfg),
        .i_item  (r_item),
        .o_sense (sense)
    );

    pocn_link u_link (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_cfg    (cfg),
        .i_item   (r_item),
        .i_sense  (sense),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_lamp_red         = r_out.lamp_red;
    assign o_lamp_yellow      = r_out.lamp_yellow;
    assign o_lamp_green       = r_out.lamp_green;
    assign o_buzzer_on        = r_out.buzzer_on;
    assign o_send_valid       = r_out.send_valid;
    assign o_send_kind        = r_out.send_kind;
    assign o_sent_occupied    = r_out.sent_occupied;
    assign o_sent_distance_mm = r_out.sent_distance_mm;
    assign o_gave_up          = r_out.gave_up;
    assign o_override_mode    = r_out.override_mode;

endmodule
